/* rtl/pru_pkg.sv */
`default_nettype none

package pru_pkg;

    localparam int MAX_SCALE = 64;

    typedef enum logic [1:0] {
        STATUS_PIXEL  = 2'd0,
        STATUS_IDLE   = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_SCALE = 1'b0,
        CFG_WIDTH = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

/* rtl/pru_ram.sv */
`default_nettype none

module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/pixel_replication_upscaler_core.sv */
`default_nettype none

// Channel   Dir  Accepted when          Contents
// s_*       in   s_tvalid && s_tready  tuser kind, tdata red/green/blue
// m_*       out  m_tvalid && m_tready  tuser status, tdata pixel/row_end/pad, tlast last
// cfg_*     in   cfg_wr_en             index 0 scale_factor, 1 input_width
//
// A pixel or a replay tick gives scale_factor output beats, one per cycle from the
// output register's copy counter; idle and reject results give a single beat.
// A request is taken while the previous one is still being copied out (one slot of
// queueing ahead of the output register); replay data is read into the line store's
// output register when the tick is taken. Reset is synchronous and resets control
// and config state, not the line store. A stalled m_tready holds the current beat.

module pixel_replication_upscaler_core
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  wire logic        s_tuser,   // kind [0]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_red [7:0], out_green [15:8],
                                        // out_blue [23:16], row_end [24],
                                        // pad_bytes [26:25], zero [31:27]
    output logic [1:0]       m_tuser,   // status [1:0]
    output logic             m_tlast    // last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (AW + 1 > CW) ? AW + 1 : CW;

    // configuration
    logic [6:0]  scale_reg;
    logic [10:0] width_reg;

    // control state
    logic [AW-1:0] wcol_reg, wcol_next;
    logic [AW-1:0] rcol_reg, rcol_next;
    logic [5:0]    rows_reg, rows_next;
    logic          replaying_reg, replaying_next;

    // request slot ahead of the output register
    logic          s1_valid_reg, s1_valid_next;
    status_t       s1_status_reg, s1_status_next;
    logic [23:0]   s1_pix_reg, s1_pix_next;
    logic          s1_from_ram_reg, s1_from_ram_next;
    logic [6:0]    s1_count_reg, s1_count_next;
    logic          s1_end_reg, s1_end_next;
    logic [1:0]    s1_pad_reg, s1_pad_next;

    // output register with copy counter
    logic          s2_valid_reg, s2_valid_next;
    status_t       s2_status_reg, s2_status_next;
    logic [23:0]   s2_pix_reg, s2_pix_next;
    logic [6:0]    s2_left_reg, s2_left_next;
    logic          s2_end_reg, s2_end_next;
    logic [1:0]    s2_pad_reg, s2_pad_next;

    logic [CW-1:0] width_eff;
    logic [6:0]    scale_eff;
    logic [1:0]    pad_val;
    logic [3:0]    pad_prod;
    logic [3:0]    pad_trip;

    logic          m_fire, s2_done, s2_free, s1_move, s_fire;
    logic          ram_wr_en, ram_rd_en;
    logic [23:0]   ram_rd_data;
    logic [EW-1:0] wcol_inc, rcol_inc;
    logic          wend, rend;
    logic [5:0]    rows_dec;
    logic          last_beat;

    pru_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wcol_reg),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (rcol_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 7'd1;
            width_reg <= 11'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SCALE: scale_reg <= cfg_wdata[6:0];
                CFG_WIDTH: width_reg <= cfg_wdata;
                default:   scale_reg <= scale_reg;
            endcase
        end
    end

    always_comb begin
        if (scale_reg == 7'd0) begin
            scale_eff = 7'd1;
        end else if (scale_reg > 7'(MAX_SCALE)) begin
            scale_eff = 7'(MAX_SCALE);
        end else begin
            scale_eff = scale_reg;
        end
        if (width_reg == 11'd0) begin
            width_eff = CW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = CW'(width_reg);
        end
    end

    // 3 bytes per pixel: pad = -(w * s * 3) mod 4
    assign pad_prod = {2'b00, 2'(width_eff)} * {2'b00, scale_eff[1:0]};
    assign pad_trip = pad_prod + {pad_prod[2:0], 1'b0};
    assign pad_val  = 2'd0 - pad_trip[1:0];

    assign m_fire    = s2_valid_reg && m_tready;
    assign s2_done   = m_fire && (s2_left_reg == 7'd1);
    assign s2_free   = !s2_valid_reg || s2_done;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s_tready  = !s1_valid_reg || s1_move;
    assign s_fire    = s_tvalid && s_tready;

    assign ram_wr_en = s_fire && (kind_t'(s_tuser) == KIND_PIXEL) && !replaying_reg;
    assign ram_rd_en = s_fire && (kind_t'(s_tuser) == KIND_TICK) && replaying_reg;

    assign wcol_inc  = EW'(wcol_reg) + EW'(1);
    assign rcol_inc  = EW'(rcol_reg) + EW'(1);
    assign wend      = wcol_inc >= EW'(width_eff);
    assign rend      = rcol_inc >= EW'(width_eff);
    assign rows_dec  = (rows_reg != 6'd0) ? rows_reg - 6'd1 : rows_reg;

    always_comb begin
        wcol_next        = wcol_reg;
        rcol_next        = rcol_reg;
        rows_next        = rows_reg;
        replaying_next   = replaying_reg;

        s1_valid_next    = s1_valid_reg && !s1_move;
        s1_status_next   = s1_status_reg;
        s1_pix_next      = s1_pix_reg;
        s1_from_ram_next = s1_from_ram_reg;
        s1_count_next    = s1_count_reg;
        s1_end_next      = s1_end_reg;
        s1_pad_next      = s1_pad_reg;

        if (s_fire) begin
            s1_valid_next    = 1'b1;
            s1_pix_next      = 24'd0;
            s1_from_ram_next = 1'b0;
            s1_count_next    = 7'd1;
            s1_end_next      = 1'b0;
            s1_pad_next      = pad_val;
            if (kind_t'(s_tuser) == KIND_PIXEL) begin
                if (replaying_reg) begin
                    s1_status_next = STATUS_REJECT;
                end else begin
                    s1_status_next = STATUS_PIXEL;
                    s1_pix_next    = s_tdata;
                    s1_count_next  = scale_eff;
                    s1_end_next    = wend;
                    wcol_next      = wend ? '0 : AW'(wcol_inc);
                    if (wend && scale_eff > 7'd1) begin
                        replaying_next = 1'b1;
                        rows_next      = 6'(scale_eff - 7'd1);
                        rcol_next      = '0;
                    end
                end
            end else begin
                if (!replaying_reg) begin
                    s1_status_next = STATUS_IDLE;
                end else begin
                    s1_status_next   = STATUS_PIXEL;
                    s1_from_ram_next = 1'b1;
                    s1_count_next    = scale_eff;
                    s1_end_next      = rend;
                    rcol_next        = rend ? '0 : AW'(rcol_inc);
                    if (rend) begin
                        rows_next = rows_dec;
                        if (rows_dec == 6'd0) begin
                            replaying_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        s2_valid_next  = s2_valid_reg && !s2_done;
        s2_status_next = s2_status_reg;
        s2_pix_next    = s2_pix_reg;
        s2_left_next   = s2_left_reg;
        s2_end_next    = s2_end_reg;
        s2_pad_next    = s2_pad_reg;
        if (s1_move) begin
            s2_valid_next  = 1'b1;
            s2_status_next = s1_status_reg;
            s2_pix_next    = s1_from_ram_reg ? ram_rd_data : s1_pix_reg;
            s2_left_next   = s1_count_reg;
            s2_end_next    = s1_end_reg;
            s2_pad_next    = s1_pad_reg;
        end else if (m_fire && !s2_done) begin
            // advance to the next copy
            s2_left_next = s2_left_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcol_reg      <= '0;
            rcol_reg      <= '0;
            rows_reg      <= 6'd0;
            replaying_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end else begin
            wcol_reg      <= wcol_next;
            rcol_reg      <= rcol_next;
            rows_reg      <= rows_next;
            replaying_reg <= replaying_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_status_reg   <= s1_status_next;
        s1_pix_reg      <= s1_pix_next;
        s1_from_ram_reg <= s1_from_ram_next;
        s1_count_reg    <= s1_count_next;
        s1_end_reg      <= s1_end_next;
        s1_pad_reg      <= s1_pad_next;
        s2_status_reg   <= s2_status_next;
        s2_pix_reg      <= s2_pix_next;
        s2_left_reg     <= s2_left_next;
        s2_end_reg      <= s2_end_next;
        s2_pad_reg      <= s2_pad_next;
    end

    assign last_beat = (s2_left_reg == 7'd1);

    assign m_tvalid = s2_valid_reg;
    assign m_tuser  = s2_status_reg;
    assign m_tlast  = last_beat;
    assign m_tdata  = {5'b00000,
                       (s2_end_reg && last_beat) ? s2_pad_reg : 2'b00,
                       s2_end_reg && last_beat,
                       s2_pix_reg};

endmodule

`default_nettype wire

/* tb/sv/pixel_replication_upscaler_core_tb.sv */
`timescale 1ns / 100ps

module pixel_replication_upscaler_core_tb;
    import pru_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 180;

    typedef struct packed {
        status_t     status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        row_end;
        logic [1:0]  pad;
        logic        last;
    } beat_t;

    typedef struct packed {
        bit          is_cfg;
        logic [10:0] scale_w;
        logic [10:0] width_w;
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        bit          typed;
        status_t     t_status;
        logic        t_end;
        logic [1:0]  t_pad;
    } plan_row_t;

    localparam int N_PLAN = 26;
    localparam plan_row_t PLAN [N_PLAN] = '{
        // reset state: scale 1, width 1, every pixel ends its row
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, STATUS_PIXEL, 1'b1, 2'd1},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_PIXEL, 1'b1, 2'd1},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1, STATUS_IDLE,  1'b0, 2'd0},
        '{1'b1, 11'd3,   11'd2,   KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'hA5, 8'h5A, 8'h3C, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        // tick mid-row: nothing to replay yet
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'hFF, 8'h00, 8'hFF, 1'b1, STATUS_IDLE,  1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h12, 8'h34, 8'h56, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        // pixel during replay is dropped
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h99, 8'h99, 8'h99, 1'b1, STATUS_REJECT, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1, STATUS_IDLE,  1'b0, 2'd0},
        // scale above range saturates at the maximum; widest rows
        '{1'b1, 11'd127, 11'd1024, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h80, 8'h01, 8'hFE, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b1, 11'd127, 11'd2047, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h7F, 8'h80, 8'h01, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h01, 8'h02, 8'h04, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        // shrink the width below the write column: next pixel closes the row
        '{1'b1, 11'd2,   11'd2,   KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h55, 8'hAA, 8'h55, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        // zero scale and zero width act as one
        '{1'b1, 11'd0,   11'd0,   KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, STATUS_PIXEL, 1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'h40, 8'h20, 8'h10, 1'b1, STATUS_PIXEL, 1'b1, 2'd1},
        '{1'b0, 11'd0,   11'd0,   KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1, STATUS_IDLE,  1'b0, 2'd0},
        '{1'b0, 11'd0,   11'd0,   KIND_PIXEL, 8'hFE, 8'h7F, 8'h80, 1'b1, STATUS_PIXEL, 1'b1, 2'd1}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_index = CFG_SCALE;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // red [7:0], green [15:8], blue [23:16]
    logic        s_tuser   = 1'b0; // kind [0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // out_red [7:0], out_green [15:8], out_blue [23:16],
                                   // row_end [24], pad_bytes [26:25], zero [31:27]
    logic [1:0]  m_tuser;          // status [1:0]
    logic        m_tlast;          // last

    // predictor copy of the registers and row state
    logic [6:0]  scale_reg = 7'd1;
    logic [10:0] width_reg = 11'd1;
    logic [23:0] line_buf [MAX_W];
    int unsigned wr_col    = 0;
    int unsigned rd_col    = 0;
    int unsigned rows_left = 0;
    bit          replay_on = 1'b0;
    int unsigned rows_seen = 0;

    beat_t       step_beats [$];
    beat_t       beats_due [$];
    int unsigned bad_beats   = 0;
    int unsigned cycle_count = 0;
    bit          steady      = 1'b0;

    pixel_replication_upscaler_core #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic beat_t mk_beat(status_t st, logic [23:0] px, logic row_end,
                                      logic [1:0] pad, logic lst);
        beat_t bt;
        bt.status  = st;
        bt.red     = px[23:16];
        bt.green   = px[15:8];
        bt.blue    = px[7:0];
        bt.row_end = row_end;
        bt.pad     = pad;
        bt.last    = lst;
        return bt;
    endfunction

    function automatic string show(beat_t bt);
        return $sformatf("status=%0d rgb=%02h%02h%02h row_end=%0b pad=%0d last=%0b",
                         bt.status, bt.red, bt.green, bt.blue, bt.row_end, bt.pad,
                         bt.last);
    endfunction

    // Work out the output beats of one request and advance the row state.
    task automatic predict_upscale(input kind_t k, input logic [7:0] r, g, b);
        int unsigned s;
        int unsigned w;
        logic [1:0]  pad;
        logic [23:0] px;
        bit          row_done;
        step_beats.delete();
        s = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
        // rows are 3 bytes per pixel, padded to a multiple of 4 bytes
        pad = 2'((4 - (((w % 4) * (s % 4) * 3) % 4)) % 4);
        row_done = 1'b0;
        if (k == KIND_PIXEL && replay_on) begin
            step_beats.push_back(mk_beat(STATUS_REJECT, '0, 1'b0, 2'd0, 1'b1));
        end else if (k == KIND_TICK && !replay_on) begin
            step_beats.push_back(mk_beat(STATUS_IDLE, '0, 1'b0, 2'd0, 1'b1));
        end else begin
            if (k == KIND_PIXEL) begin
                px = {r, g, b};
                wr_col = wr_col % MAX_W;
                line_buf[wr_col] = px;
                wr_col++;
                row_done = (wr_col >= w);
                if (row_done) begin
                    wr_col = 0;
                    rows_seen++;
                    if (s > 1) begin
                        replay_on = 1'b1;
                        rows_left = s - 1;
                        rd_col    = 0;
                    end
                end
            end else begin
                rd_col = rd_col % MAX_W;
                px = line_buf[rd_col];
                rd_col++;
                row_done = (rd_col >= w);
                if (row_done) begin
                    rd_col = 0;
                    if (rows_left > 0) rows_left--;
                    if (rows_left == 0) replay_on = 1'b0;
                end
            end
            for (int i = 0; i < s; i++) begin
                step_beats.push_back(mk_beat(STATUS_PIXEL, px, row_done && i == s - 1,
                                             (row_done && i == s - 1) ? pad : 2'd0,
                                             i == s - 1));
            end
        end
    endtask

    task automatic issue(input kind_t k, input logic [7:0] r, g, b,
                         input bit typed, input beat_t typed_beat);
        if (!steady) begin
            while ($urandom_range(0, 99) < 30) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        predict_upscale(k, r, g, b);
        if (typed) begin
            beats_due.push_back(typed_beat);
        end else begin
            foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
        end
    endtask

    // Hold off requests until every outstanding beat has been taken.
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [10:0] sc, input logic [10:0] wd);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SCALE;
        cfg_wdata <= sc;
        @(posedge aclk);
        cfg_index <= CFG_WIDTH;
        cfg_wdata <= wd;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scale_reg = sc[6:0];
        width_reg = wd;
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge aclk) begin : watch_results
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = status_t'(m_tuser);
            got.red     = m_tdata[7:0];
            got.green   = m_tdata[15:8];
            got.blue    = m_tdata[23:16];
            got.row_end = m_tdata[24];
            got.pad     = m_tdata[26:25];
            got.last    = m_tlast;
            if (beats_due.size() == 0) begin
                if (bad_beats < 10) $display("unexpected beat: %s", show(got));
                bad_beats++;
            end else begin
                want = beats_due.pop_front();
                if (got !== want || m_tdata[31:27] !== 5'd0) begin
                    if (bad_beats < 10) begin
                        $display("beat mismatch: expected %s, got %s, tdata[31:27]=%b",
                                 show(want), show(got), m_tdata[31:27]);
                    end
                    bad_beats++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        plan_row_t   row;
        int unsigned rand_items;
        int unsigned phase;
        int unsigned rows_goal;
        logic [10:0] sc;
        logic [10:0] wd;
        kind_t       k;
        rand_items = 0;
        phase      = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_PLAN; i++) begin
            row = PLAN[i];
            if (row.is_cfg) begin
                drain_results();
                program_regs(row.scale_w, row.width_w);
            end else begin
                issue(row.kind, row.red, row.green, row.blue, row.typed,
                      mk_beat(row.t_status, (row.t_status == STATUS_PIXEL) ?
                              {row.red, row.green, row.blue} : 24'd0,
                              row.t_end, row.t_pad, 1'b1));
            end
        end

        // whole rows with their repeat rows, salted with stray pixels and ticks
        while (rand_items < RAND_ITEMS) begin
            if (phase == 0) begin
                sc = 11'd64;
                wd = 11'd1;
            end else if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        sc = 11'd0;
                    end
                    1: begin
                        sc = 11'd127;
                    end
                    default: begin
                        sc = 11'd64;
                    end
                endcase
                wd = 11'($urandom_range(1, 2));
            end else begin
                sc = 11'($urandom_range(1, 6));
                wd = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
            end
            drain_results();
            program_regs(sc, wd);
            rows_goal = rows_seen + $urandom_range(1, 2);
            while (replay_on || rows_seen < rows_goal) begin
                steady = (rand_items >= 60 && rand_items < 110);
                if ($urandom_range(0, 39) == 0) begin
                    drain_results();
                end else if (!replay_on && wr_col != 0 && $urandom_range(0, 14) == 0) begin
                    // change the registers part-way through an input row
                    drain_results();
                    program_regs(11'($urandom_range(1, 4)), 11'($urandom_range(1, 6)));
                end
                if (replay_on) begin
                    k = ($urandom_range(0, 9) == 0) ? KIND_PIXEL : KIND_TICK;
                end else begin
                    k = ($urandom_range(0, 9) == 0) ? KIND_TICK : KIND_PIXEL;
                end
                issue(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'b0, '0);
                rand_items++;
            end
            phase++;
        end
        steady = 1'b0;

        drain_results();
        repeat (12) @(posedge aclk);
        if (bad_beats == 0 && beats_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/pru_pkg.sv
rtl/pru_ram.sv
rtl/pixel_replication_upscaler_core.sv
tb/sv/pixel_replication_upscaler_core_tb.sv
